[design/pdlr_pkg.sv]
// Package: shared types and constants for the PCM downmix resampler.
`timescale 1ns / 1ps
package pdlr_pkg;

    localparam int Q_ONE_W = 25;
    localparam logic signed [24:0] Q_ONE = 25'sd8388608;

    typedef enum logic [1:0] {
        FMT_U8  = 2'd0,
        FMT_I16 = 2'd1,
        FMT_I32 = 2'd2,
        FMT_F32 = 2'd3
    } fmt_t;

    typedef enum logic [1:0] {
        REG_FORMAT   = 2'd0,
        REG_CHANNELS = 2'd1,
        REG_STEP     = 2'd2,
        REG_ENABLE   = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MIX,
        ST_DIV,
        ST_INTERP,
        ST_MUL,
        ST_OUT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic clear;
        logic take_byte;
        logic div_start;
        logic interp_load;
        logic mul_load;
        logic out_load;
        logic out_last;
        logic mono_finish;
        logic store_first;
        logic skip_sample;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic sample_done;
        logic frame_done;
        logic div_busy;
        logic have_prev;
        logic phase_below_one;
        logic more_after;
    } stat_t;

    // Round a Q1.23 value to int16.
    function automatic logic [15:0] to_pcm(input logic signed [25:0] v);
        logic signed [25:0] c;
        logic [40:0] m;
        logic [17:0] r;
        begin
            c = v;
            if (c > 26'sd8388608)
                c = 26'sd8388608;
            m = (c < 0) ? 41'(-c) * 41'd32767 : 41'(c) * 41'd32767;
            r = 18'((m + 41'd4194304) >> 23);
            if (v <= -26'sd8388608)
                to_pcm = 16'h8000;
            else if (c < 0)
                to_pcm = 16'(-r);
            else
                to_pcm = r[15:0];
        end
    endfunction

endpackage

[design/pdlr_ctrl.sv]
// Controller: sequences byte intake, division, interpolation and output.
`timescale 1ns / 1ps
module pdlr_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  data_valid,
    output logic                  data_ready,
    input  logic                  cfg_valid,
    input  logic                  enable,
    input  pdlr_pkg::stat_t       stat,
    input  logic                  out_free,
    output pdlr_pkg::cmd_t        cmd
);
    import pdlr_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (!cfg_valid && data_valid)
                    state_next = ST_MIX;
            ST_MIX:
                if (!stat.sample_done || !stat.frame_done)
                    state_next = ST_IDLE;
                else
                    state_next = ST_DIV;
            ST_DIV:
                if (!stat.div_busy)
                begin
                    if (!enable)
                        state_next = ST_OUT;
                    else if (!stat.have_prev || !stat.phase_below_one)
                        state_next = ST_IDLE;
                    else
                        state_next = ST_INTERP;
                end
            ST_INTERP:
                state_next = ST_MUL;
            ST_MUL:
                state_next = ST_OUT;
            ST_OUT:
                if (out_free)
                    state_next = (enable && stat.more_after) ? ST_INTERP : ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        data_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                data_ready = !cfg_valid;
                cmd.take_byte = data_valid && !cfg_valid;
            end
            ST_MIX:
                cmd.div_start = stat.sample_done && stat.frame_done;
            ST_DIV:
                if (!stat.div_busy)
                begin
                    cmd.mono_finish = 1'b1;
                    cmd.store_first = enable && !stat.have_prev;
                    cmd.skip_sample = enable && stat.have_prev && !stat.phase_below_one;
                end
            ST_INTERP:
                cmd.interp_load = 1'b1;
            ST_MUL:
                cmd.mul_load = 1'b1;
            ST_OUT:
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = !(enable && stat.more_after);
                end
            default: ;
        endcase
        cmd.clear = cfg_valid && (state_reg == ST_IDLE);
    end

endmodule

[design/pdlr_dp.sv]
// Datapath: sample assembly, decode, mix, divide, interpolate, round.
`timescale 1ns / 1ps
module pdlr_dp
#(
    parameter int MAX_CHANNELS    = 8,
    parameter int PHASE_FRAC_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  pdlr_pkg::cmd_t        cmd,
    input  logic [7:0]            data_byte,
    input  logic [1:0]            sample_format,
    input  logic [3:0]            channel_count,
    input  logic [20:0]           phase_step,
    output pdlr_pkg::stat_t       stat,
    output logic [15:0]           out_value
);
    import pdlr_pkg::*;

    localparam int PW   = PHASE_FRAC_BITS + 5;
    localparam int CHW  = $clog2(MAX_CHANNELS + 1);
    localparam int SUMW = Q_ONE_W + CHW + 1;
    localparam logic [PW-1:0] ONE = PW'(1) << PHASE_FRAC_BITS;

    logic [1:0]             bpos_reg;
    logic [23:0]            part_reg;
    logic [CHW-1:0]         chpos_reg;
    logic signed [SUMW-1:0] sum_reg;
    logic signed [24:0]     prev_reg;
    logic                   havep_reg;
    logic [PW-1:0]          phase_reg;
    logic                   sdone_reg, fdone_reg;
    logic signed [24:0]     mono_reg;
    logic [PW-1:0]          step_c;
    logic [CHW-1:0]         nch;

    // serial divider (magnitude, restoring)
    logic [SUMW-1:0]        dq_reg;
    logic [CHW:0]           drem_reg;
    logic                   dneg_reg;
    logic [$clog2(SUMW+1)-1:0] dcnt_reg;
    logic                   dbusy_reg;

    logic [49:0]            pa_reg, pb_reg;
    logic signed [25:0]     interp_reg;
    logic [15:0]            out_reg;

    // decode
    logic [31:0]            raw;
    logic signed [24:0]     dec;
    logic [7:0]             ex;
    logic [24:0]            fmag;
    logic [1:0]             nbm1;

    always_comb
    begin
        case (sample_format)
            FMT_U8:  nbm1 = 2'd0;
            FMT_I16: nbm1 = 2'd1;
            default: nbm1 = 2'd3;
        endcase
        raw = {8'd0, part_reg} | (32'(data_byte) << {bpos_reg, 3'b000});
        ex = raw[30:23];
        if (ex >= 8'd127)
            fmag = 25'd8388608;
        else if (ex == 8'd0 || (8'd127 - ex) >= 8'd32)
            fmag = '0;
        else
            fmag = 25'({1'b1, raw[22:0]} >> (8'd127 - ex));
        case (sample_format)
            FMT_U8:  dec = 25'(signed'({1'b0, raw[7:0]}) - 10'sd128) <<< 16;
            FMT_I16: dec = 25'(signed'(raw[15:0])) <<< 8;
            FMT_I32: dec = 25'(signed'(raw[31:8]));
            default: dec = (ex == 8'hFF) ? '0 : (raw[31] ? -fmag : fmag);
        endcase
        if (channel_count == 4'd0)
            nch = CHW'(1);
        else if (32'(channel_count) > MAX_CHANNELS)
            nch = CHW'(MAX_CHANNELS);
        else
            nch = CHW'(channel_count);
        if ({11'd0, phase_step} < (32'(ONE) >> 2))
            step_c = ONE >> 2;
        else if ({11'd0, phase_step} > 32'(ONE) * 16)
            step_c = PW'(32'(ONE) * 16);
        else
            step_c = PW'(phase_step);
    end

    logic [SUMW-1:0] sum_mag;
    logic [CHW:0]    trial;
    assign sum_mag = sum_reg[SUMW-1] ? SUMW'(-sum_reg) : SUMW'(sum_reg);
    assign trial   = {drem_reg[CHW-1:0], dq_reg[SUMW-1]};

    logic signed [SUMW:0] qs;
    logic signed [24:0]   mono_c;
    always_comb
    begin
        qs = dneg_reg ? -(SUMW+1)'(dq_reg) : (SUMW+1)'(dq_reg);
        if (qs > (SUMW+1)'(Q_ONE))
            mono_c = Q_ONE;
        else if (qs < -(SUMW+1)'(Q_ONE))
            mono_c = -Q_ONE;
        else
            mono_c = 25'(qs);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpos_reg  <= '0;
            part_reg  <= '0;
            chpos_reg <= '0;
            sum_reg   <= '0;
            prev_reg  <= '0;
            havep_reg <= 1'b0;
            phase_reg <= '0;
            sdone_reg <= 1'b0;
            fdone_reg <= 1'b0;
            dbusy_reg <= 1'b0;
            dcnt_reg  <= '0;
        end
        else if (cmd.clear)
        begin
            bpos_reg  <= '0;
            part_reg  <= '0;
            chpos_reg <= '0;
            sum_reg   <= '0;
            prev_reg  <= '0;
            havep_reg <= 1'b0;
            phase_reg <= '0;
        end
        else
        begin
            if (cmd.take_byte)
            begin
                if (bpos_reg < nbm1)
                begin
                    part_reg  <= raw[23:0];
                    bpos_reg  <= bpos_reg + 2'd1;
                    sdone_reg <= 1'b0;
                end
                else
                begin
                    part_reg  <= '0;
                    bpos_reg  <= '0;
                    sdone_reg <= 1'b1;
                    sum_reg   <= sum_reg + SUMW'(dec);
                    fdone_reg <= (chpos_reg + CHW'(1)) >= nch;
                    chpos_reg <= ((chpos_reg + CHW'(1)) >= nch) ? '0 : chpos_reg + CHW'(1);
                end
            end
            if (cmd.div_start)
            begin
                dq_reg    <= sum_mag;
                dneg_reg  <= sum_reg[SUMW-1];
                drem_reg  <= '0;
                dcnt_reg  <= ($clog2(SUMW+1))'(SUMW);
                dbusy_reg <= 1'b1;
                sum_reg   <= '0;
            end
            else if (dbusy_reg)
            begin
                // one quotient bit per cycle
                if (trial >= {1'b0, nch})
                begin
                    drem_reg <= trial - {1'b0, nch};
                    dq_reg   <= {dq_reg[SUMW-2:0], 1'b1};
                end
                else
                begin
                    drem_reg <= trial;
                    dq_reg   <= {dq_reg[SUMW-2:0], 1'b0};
                end
                dcnt_reg <= dcnt_reg - 1'b1;
                if (dcnt_reg == 1)
                    dbusy_reg <= 1'b0;
            end
            if (cmd.mono_finish)
            begin
                mono_reg <= mono_c;
                if (cmd.store_first)
                begin
                    prev_reg  <= mono_c;
                    havep_reg <= 1'b1;
                end
                if (cmd.skip_sample)
                begin
                    // no output falls before this sample: advance past it
                    phase_reg <= phase_reg - ONE;
                    prev_reg  <= mono_c;
                end
            end
            if (cmd.interp_load)
            begin
                pa_reg <= 50'({1'b0, 25'(prev_reg + Q_ONE)}) * 50'(ONE - phase_reg);
                pb_reg <= 50'({1'b0, 25'(mono_reg + Q_ONE)}) * 50'(phase_reg);
                phase_reg <= phase_reg + step_c;
            end
            if (cmd.mul_load)
                interp_reg <= 26'(signed'({1'b0, 25'((pa_reg + pb_reg) >> PHASE_FRAC_BITS)}))
                              - 26'(Q_ONE);
            if (cmd.out_load)
            begin
                out_reg <= to_pcm(cmd.out_last && !havep_reg ? 26'(mono_reg) : interp_reg);
                if (havep_reg && cmd.out_last)
                begin
                    phase_reg <= phase_reg - ONE;
                    prev_reg  <= mono_reg;
                end
            end
        end
    end

    // count of outputs this sample is bounded to four by the step clamp
    assign stat.sample_done     = sdone_reg;
    assign stat.frame_done      = fdone_reg;
    assign stat.div_busy        = dbusy_reg;
    assign stat.have_prev       = havep_reg;
    assign stat.phase_below_one = phase_reg < ONE;
    assign stat.more_after      = phase_reg < ONE;
    assign out_value            = out_reg;

endmodule

[design/pcm_downmix_linear_resampler.sv]
// Top level: PCM downmix and linear resampler.
`timescale 1ns / 1ps
// Sequence: a frame's last byte is mixed, divided by the 30-step channel divider,
// then rounded out in bypass or interpolated and multiplied first. Bytes that
// complete no frame pass the mix state before the next is taken; interpolated
// outputs add interpolate, multiply and round steps; a stalled output holds.
// Reset: rst_n clears all stream state and loads int16, one channel, step 1.0, bypass.
module pcm_downmix_linear_resampler
#(
    parameter int MAX_CHANNELS    = 8,
    parameter int PHASE_FRAC_BITS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         data_valid,
    output logic         data_ready,
    input  logic [7:0]   data_byte,
    output logic         pcm_valid,
    input  logic         pcm_ready,
    output logic [15:0]  pcm_sample,
    output logic         last_of_run,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [20:0]  cfg_data
);
    import pdlr_pkg::*;

    cmd_t  cmd;
    stat_t stat;
    logic [15:0] value;
    logic [1:0]  fmt_reg;
    logic [3:0]  nch_reg;
    logic [20:0] step_reg;
    logic        en_reg;
    logic        ovalid_reg;
    logic        olast_reg;
    logic        out_free;

    // Take configuration only while idle; the write also clears the stream.
    assign cfg_ready = cmd.clear;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg  <= FMT_I16;
            nch_reg  <= 4'd1;
            step_reg <= 21'(32'd1 << PHASE_FRAC_BITS);
            en_reg   <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_FORMAT:   fmt_reg  <= cfg_data[1:0];
                REG_CHANNELS: nch_reg  <= cfg_data[3:0];
                REG_STEP:     step_reg <= cfg_data;
                REG_ENABLE:   en_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Output register: free when empty or being drained this cycle.
    assign out_free = !ovalid_reg || pcm_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
            olast_reg  <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            ovalid_reg <= 1'b1;
            olast_reg  <= cmd.out_last;
        end
        else if (pcm_ready)
            ovalid_reg <= 1'b0;
    end

    pdlr_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .data_valid (data_valid),
        .data_ready (data_ready),
        .cfg_valid  (cfg_valid && !ovalid_reg),
        .enable     (en_reg),
        .stat       (stat),
        .out_free   (out_free),
        .cmd        (cmd)
    );

    pdlr_dp #(
        .MAX_CHANNELS    (MAX_CHANNELS),
        .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
    ) u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .data_byte     (data_byte),
        .sample_format (fmt_reg),
        .channel_count (nch_reg),
        .phase_step    (step_reg),
        .stat          (stat),
        .out_value     (value)
    );

    assign pcm_valid   = ovalid_reg;
    assign pcm_sample  = value;
    assign last_of_run = olast_reg;

endmodule

[design/pdlr_checker.sv]
// Checker: port-level properties of the resampler, bound to the top level.
`timescale 1ns / 1ps
module pdlr_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        data_valid,
    input logic        data_ready,
    input logic        pcm_valid,
    input logic        pcm_ready,
    input logic [15:0] pcm_sample,
    input logic        last_of_run,
    input logic        cfg_valid,
    input logic        cfg_ready
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pcm_valid && !pcm_ready |=> pcm_valid && $stable(pcm_sample))
        else $error("output changed while stalled");

    a_no_cfg_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        pcm_valid |-> !cfg_ready)
        else $error("config taken with result pending");

    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(cfg_ready && data_ready && data_valid && cfg_valid))
        else $error("config and data transfer together");

    a_no_take_after: assert property (@(posedge clk) disable iff (!rst_n)
        data_valid && data_ready |=> !data_ready)
        else $error("byte taken back to back");
endmodule

bind pcm_downmix_linear_resampler pdlr_checker u_pdlr_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .data_valid  (data_valid),
    .data_ready  (data_ready),
    .pcm_valid   (pcm_valid),
    .pcm_ready   (pcm_ready),
    .pcm_sample  (pcm_sample),
    .last_of_run (last_of_run),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready)
);
